// ----- src/sha_pkg.sv -----
`default_nettype none

package sha_pkg;

  localparam int unsigned BlockBits = 512;

  typedef struct packed {
    logic                 last_blk;
    logic [BlockBits-1:0] data;
  } blk_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

// ----- src/sha_front.sv -----
`default_nettype none

module sha_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [31:0]   data_word_i,
  input  wire logic [2:0]    byte_count_i,
  input  wire logic          end_of_message_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output sha_pkg::blk_t      push_blk_o
);

  typedef enum logic [2:0] {
    F_ACCEPT = 3'b001,
    F_PAD    = 3'b010,
    F_LEN    = 3'b100
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [5:0]  pos_q, pos_d;
  logic [63:0] len_q, len_d;
  logic [511:0] blk_q, blk_d;

  logic [2:0]   cnt;
  logic [6:0]   sum;
  logic [511:0] cur;
  logic [511:0] wrap;
  logic [511:0] padb;
  logic         acc;

  always_comb begin
    logic [6:0] p;
    cnt = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    sum = {1'b0, pos_q} + {4'b0000, cnt};
    cur = blk_q;
    for (int i = 0; i < 4; i++) begin
      p = {1'b0, pos_q} + 7'(i);
      if (3'(i) < cnt && !p[6]) begin
        cur[9'd511 - {p[5:0], 3'b000} -: 8] = data_word_i[31-8*i -: 8];
      end
    end
    wrap = cur;
    for (int i = 0; i < 4; i++) begin
      p = {1'b0, pos_q} + 7'(i);
      if (3'(i) < cnt && p[6]) begin
        wrap[9'd511 - {p[5:0], 3'b000} -: 8] = data_word_i[31-8*i -: 8];
      end
    end
    padb = blk_q;
    for (int b = 0; b < 64; b++) begin
      if (6'(b) == pos_q) begin
        padb[511-8*b -: 8] = 8'h80;
      end else if (6'(b) > pos_q) begin
        padb[511-8*b -: 8] = 8'h00;
      end
    end
    if (pos_q < 6'd56) begin
      padb[63:0] = len_q;
    end
  end

  assign in_ready_o = (state_q == F_ACCEPT) && !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d             = state_q;
    pos_d               = pos_q;
    len_d               = len_q;
    blk_d               = blk_q;
    push_o              = 1'b0;
    push_blk_o.last_blk = 1'b0;
    push_blk_o.data     = cur;
    unique case (state_q)
      F_ACCEPT: begin
        if (acc) begin
          blk_d  = wrap;
          pos_d  = sum[5:0];
          len_d  = len_q + {58'd0, cnt, 3'b000};
          push_o = sum[6];
          if (end_of_message_i) begin
            state_d = F_PAD;
          end
        end
      end
      F_PAD: begin
        push_blk_o.data = padb;
        if (!q_full_i) begin
          push_o = 1'b1;
          if (pos_q < 6'd56) begin
            push_blk_o.last_blk = 1'b1;
            pos_d               = '0;
            len_d               = '0;
            state_d             = F_ACCEPT;
          end else begin
            state_d = F_LEN;
          end
        end
      end
      F_LEN: begin
        push_blk_o.data     = {448'd0, len_q};
        push_blk_o.last_blk = 1'b1;
        if (!q_full_i) begin
          push_o  = 1'b1;
          pos_d   = '0;
          len_d   = '0;
          state_d = F_ACCEPT;
        end
      end
      default: state_d = F_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_ACCEPT;
      pos_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule

`default_nettype wire

// ----- src/sha_queue.sv -----
`default_nettype none

module sha_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sha_pkg::blk_t push_blk_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output sha_pkg::blk_t      pop_blk_o
);

  sha_pkg::blk_t ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_blk_o = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_blk_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/sha_back.sv -----
`default_nettype none

module sha_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire sha_pkg::blk_t q_blk_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        digest_word_o,
  output logic               digest_last_o
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_EMIT  = 4'b1000
  } bstate_e;

  bstate_e     state_q;
  logic [5:0]  rnd_q;
  logic        last_q;
  logic [3:0]  ocnt_q;
  logic [31:0] h_q   [8];
  logic [31:0] v_q   [8];
  logic [31:0] w_q   [16];
  logic [31:0] dig_q [8];

  logic [31:0] e, a, big0, big1, ch, maj, t1, t2, sg0, sg1, w_new;
  logic        out_hs;
  logic        emit_go;

  always_comb begin
    e     = v_q[4];
    a     = v_q[0];
    big1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch    = (e & v_q[5]) ^ (~e & v_q[6]);
    t1    = v_q[7] + big1 + ch + sha_pkg::RoundK[rnd_q] + w_q[0];
    big0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    maj   = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = big0 + maj;
    sg0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
            ^ {3'b000, w_q[1][31:3]};
    sg1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
            ^ {10'd0, w_q[14][31:10]};
    w_new = sg1 + w_q[9] + sg0 + w_q[0];
  end

  assign pop_o         = (state_q == B_IDLE) && q_valid_i;
  assign out_valid_o   = (ocnt_q != 4'd0);
  assign digest_word_o = dig_q[0];
  assign digest_last_o = (ocnt_q == 4'd1);
  assign out_hs        = out_valid_o && out_ready_i;
  assign emit_go       = (state_q == B_EMIT) && (ocnt_q == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      rnd_q   <= '0;
      last_q  <= 1'b0;
      ocnt_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::InitH[i];
      end
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            last_q  <= q_blk_i.last_blk;
            rnd_q   <= '0;
            state_q <= B_ROUND;
          end
        end
        B_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= B_ADD;
          end
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
          state_q <= last_q ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          if (emit_go) begin
            for (int i = 0; i < 8; i++) begin
              h_q[i] <= sha_pkg::InitH[i];
            end
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
      if (emit_go) begin
        ocnt_q <= 4'd8;
      end else if (out_hs) begin
        ocnt_q <= ocnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= q_blk_i.data[511-32*i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (state_q == B_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (emit_go) begin
      for (int i = 0; i < 8; i++) begin
        dig_q[i] <= h_q[i];
      end
    end else if (out_hs) begin
      for (int i = 0; i < 7; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/sha256_stream_hasher.sv -----
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   data_word_i, byte_count_i, end_of_message_i
// output    out        out_valid_o / out_ready_i digest_word_o, digest_last_o
//
// The front takes one request per cycle while the two-entry block queue has room.
// Each 64-byte block runs through the single-round compression loop, which takes the next
// block from the queue only when idle, so a stream of requests waits while the queue is full.
// A message end holds the input while the one or two pad blocks are queued.
// Reset loads the initial hash values and empties the queue and the digest register.
// The digest is held in an output register, so a stalled output only stops the
// compression loop when a second digest is ready before the first is taken.

module sha256_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic             digest_last_o
);

  logic          q_full;
  logic          q_valid;
  logic          push;
  logic          pop;
  sha_pkg::blk_t push_blk;
  sha_pkg::blk_t pop_blk;

  sha_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .push_blk_o       (push_blk)
  );

  sha_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_blk_i (push_blk),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_blk_o  (pop_blk)
  );

  sha_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_blk_i       (pop_blk),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .digest_last_o (digest_last_o)
  );

endmodule

`default_nettype wire

// ----- tb/sha256_stream_hasher_tb.sv -----
`default_nettype none

module sha256_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] HashIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int unsigned MaxWait     = 12;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 300;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [31:0] data_word      = '0;
  logic [2:0]  byte_count     = '0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;

  logic [31:0]  hash_state [8];
  logic [7:0]   block_bytes [64];
  int unsigned  block_fill;
  logic [63:0]  message_bits;
  digest_beat_t expected_digest [$];

  int unsigned error_count        = 0;
  bit          sender_full_rate   = 1'b0;
  bit          receiver_full_rate = 1'b0;
  int unsigned receiver_hold      = 0;

  sha256_stream_hasher DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_word_i      (data_word),
    .byte_count_i     (byte_count),
    .end_of_message_i (end_of_message),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .digest_word_o    (digest_word),
    .digest_last_o    (digest_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    hash_state   = HashIv;
    block_fill   = 0;
    message_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = hash_state;
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) begin
      hash_state[i] = hash_state[i] + v[i];
    end
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    block_bytes[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  function automatic void predict_request(logic [31:0] word, logic [2:0] count, logic eom);
    int unsigned n;
    int unsigned pos;
    int i;
    n = (count > 3'd4) ? 4 : count;
    for (i = 0; i < n; i++) begin
      absorb_byte(word[31-8*i -: 8]);
      message_bits = message_bits + 64'd8;
    end
    if (!eom) begin
      return;
    end
    pos = block_fill;
    block_bytes[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_bytes[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) begin
      block_bytes[63-i] = message_bits[8*i +: 8];
    end
    compress_block();
    for (i = 0; i < 8; i++) begin
      expected_digest.push_back(digest_beat_t'{word: hash_state[i], last: (i == 7)});
    end
    restart_hash();
  endfunction

  task automatic send_request(logic [31:0] word, logic [2:0] count, logic eom);
    int unsigned gap;
    gap = sender_full_rate ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_word      <= word;
    byte_count     <= count;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    predict_request(word, count, eom);
  endtask

  task automatic send_message(int unsigned nbytes, bit split_end);
    int unsigned left;
    left = nbytes;
    while (left > 4 || (left == 4 && split_end)) begin
      send_request($urandom, 3'd4, 1'b0);
      left -= 4;
    end
    send_request($urandom, 3'(left), 1'b1);
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_digest.size() != 0);
  endtask

  task automatic test_directed_cases();
    send_request(32'h00000000, 3'd0, 1'b1);
    send_request(32'h616263ff, 3'd3, 1'b1);
    send_request(32'hffffffff, 3'd4, 1'b1);
    send_request(32'h00000000, 3'd7, 1'b1);
    send_request(32'h12345678, 3'd5, 1'b0);
    send_request(32'h9abcdef0, 3'd6, 1'b0);
    send_request(32'hdeadbeef, 3'd7, 1'b1);
    send_request(32'ha5a5a5a5, 3'd1, 1'b0);
    send_request(32'h5a5a5a5a, 3'd2, 1'b0);
    send_request(32'hffffffff, 3'd0, 1'b0);
    send_request(32'hc3c3c3c3, 3'd0, 1'b1);
  endtask

  task automatic test_block_boundaries();
    send_message(55, 1'b0);
    sender_full_rate   = 1'b1;
    receiver_full_rate = 1'b1;
    send_message(56, 1'b0);
    wait_for_digests();
    sender_full_rate   = 1'b0;
    receiver_full_rate = 1'b0;
    send_message(64, 1'b1);
  endtask

  task automatic test_output_backpressure();
    wait_for_digests();
    receiver_hold    = HoldCycles;
    sender_full_rate = 1'b1;
    repeat (6) send_message($urandom_range(0, 8), 1'b0);
    sender_full_rate = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_message($urandom_range(1, 20), 1'b0);
    wait_for_digests();
    send_message($urandom_range(1, 20), 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    bit full;
    sent = 0;
    while (sent < 35) begin
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      full = ($urandom_range(0, 5) == 0);
      sender_full_rate   = full;
      receiver_full_rate = full;
      for (k = 0; k < len; k++) begin
        send_request($urandom,
                     ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4, 1'b0);
      end
      send_request($urandom, 3'($urandom_range(0, 7)), 1'b1);
      sent += len + 1;
      if ($urandom_range(0, 4) == 0) begin
        wait_for_digests();
      end
    end
    sender_full_rate   = 1'b0;
    receiver_full_rate = 1'b0;
  endtask

  initial begin : receiver
    int unsigned stall;
    wait (rst_n);
    forever begin
      if (receiver_hold != 0) begin
        stall = receiver_hold;
        receiver_hold = 0;
      end else begin
        stall = receiver_full_rate ? 0 : $urandom_range(0, MaxWait);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_digest.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual %h last %b",
                 $time, digest_word, digest_last);
        error_count++;
      end else begin
        if (digest_word !== expected_digest[0].word) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h",
                   $time, expected_digest[0].word, digest_word);
          error_count++;
        end
        if (digest_last !== expected_digest[0].last) begin
          $display("%0t: digest_last mismatch: expected %b, actual %b",
                   $time, expected_digest[0].last, digest_last);
          error_count++;
        end
        void'(expected_digest.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    restart_hash();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_block_boundaries();
    test_output_backpressure();
    test_sender_pause();
    test_random_messages();
    wait_for_digests();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sha256_stream_hasher.f -----
src/sha_pkg.sv
src/sha_front.sv
src/sha_queue.sv
src/sha_back.sv
src/sha256_stream_hasher.sv
tb/sha256_stream_hasher_tb.sv
